// ----- rtl/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// AES-128 CBC package
// S-boxes, GF(2^8) helpers, FSM state and column lane control types.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int KEY_WORDS   = 4 * (ROUND_COUNT + 1);
    localparam int RND_BITS    = $clog2(ROUND_COUNT + 1);
    localparam int CFG_BITS    = 3;

    localparam logic [CFG_BITS-1:0] REG_KEY_HIGH     = 3'd0;
    localparam logic [CFG_BITS-1:0] REG_KEY_LOW      = 3'd1;
    localparam logic [CFG_BITS-1:0] REG_IV_HIGH      = 3'd2;
    localparam logic [CFG_BITS-1:0] REG_IV_LOW       = 3'd3;
    localparam logic [CFG_BITS-1:0] REG_DECRYPT_MODE = 3'd4;
    localparam logic [CFG_BITS-1:0] REG_CHAIN_ENABLE = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // per-round lane control
    typedef struct packed {
        logic inv;
        logic first;
        logic last;
    } t_lane_ctl;

    typedef logic [7:0] t_sbox [256];

    localparam t_sbox SBOX = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};

    localparam t_sbox RSBOX = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// ----- rtl/aes_keyexp.sv -----
// ----------------------------------------------------------------------------
// AES-128 key expansion
// Expands the key one round key (four words) per cycle into a register file.
// ----------------------------------------------------------------------------
module aes_keyexp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [127:0]                 i_key,
    input  logic [aes_pkg::RND_BITS-1:0] i_rnd,
    output logic [127:0]                 o_rkey,
    output logic                         o_busy
);

    logic [127:0]                 r_rk [aes_pkg::ROUND_COUNT+1];
    logic [127:0]                 r_cur;
    logic [7:0]                   r_rc;
    logic [aes_pkg::RND_BITS-1:0] r_idx;
    logic                         r_busy;
    logic [127:0]                 n_cur;
    logic [31:0]                  w0, w1, w2, w3, t;

    always_comb begin
        t  = aes_pkg::sub_word({r_cur[23:0], r_cur[31:24]}) ^ {r_rc, 24'h0};
        w0 = r_cur[127:96] ^ t;
        w1 = r_cur[95:64] ^ w0;
        w2 = r_cur[63:32] ^ w1;
        w3 = r_cur[31:0] ^ w2;
        n_cur = {w0, w1, w2, w3};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx == aes_pkg::RND_BITS'(aes_pkg::ROUND_COUNT)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cur <= i_key;
            r_rc  <= 8'h01;
        end else if (r_busy) begin
            r_rk[r_idx] <= r_cur;
            r_cur       <= n_cur;
            r_rc        <= aes_pkg::xt(r_rc);
        end
    end

    assign o_rkey = r_rk[i_rnd];
    assign o_busy = r_busy;

endmodule

// ----- rtl/aes_lane.sv -----
// ----------------------------------------------------------------------------
// AES column lane
// One column: S-box, (inverse) mix unless last, key add; first adds key only.
// ----------------------------------------------------------------------------
module aes_lane (
    input  aes_pkg::t_lane_ctl i_ctl,
    input  logic [31:0]        i_col,
    input  logic [31:0]        i_key,
    output logic [31:0]        o_col
);

    logic [7:0] s [4];
    logic [7:0] m [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [31:0] k;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            s[r] = i_ctl.inv ? aes_pkg::RSBOX[i_col[31-8*r -: 8]]
                             : aes_pkg::SBOX[i_col[31-8*r -: 8]];
        end
        // inverse order adds the key before the mix
        k = {s[0], s[1], s[2], s[3]} ^ (i_ctl.inv ? i_key : 32'h0);
        for (int r = 0; r < 4; r++) begin
            x2[r] = aes_pkg::xt(k[31-8*r -: 8]);
            x4[r] = aes_pkg::xt(x2[r]);
            x8[r] = aes_pkg::xt(x4[r]);
        end
        for (int r = 0; r < 4; r++) begin
            if (i_ctl.inv) begin
                m[r] = (x8[r] ^ x4[r] ^ x2[r])
                     ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ k[31-8*((r+1)%4) -: 8])
                     ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ k[31-8*((r+2)%4) -: 8])
                     ^ (x8[(r+3)%4] ^ k[31-8*((r+3)%4) -: 8]);
            end else begin
                m[r] = x2[r] ^ (x2[(r+1)%4] ^ k[31-8*((r+1)%4) -: 8])
                     ^ k[31-8*((r+2)%4) -: 8] ^ k[31-8*((r+3)%4) -: 8];
            end
        end
        if (i_ctl.first) begin
            o_col = i_col ^ i_key;
        end else if (i_ctl.last) begin
            o_col = k ^ (i_ctl.inv ? 32'h0 : i_key);
        end else if (i_ctl.inv) begin
            o_col = {m[0], m[1], m[2], m[3]};
        end else begin
            o_col = {m[0], m[1], m[2], m[3]} ^ i_key;
        end
    end

endmodule

// ----- rtl/aes_core.sv -----
// ----------------------------------------------------------------------------
// AES round datapath
// Four column lanes fed by shift rows (a loaded block goes in unshifted); merges lane outputs into the state.
// ----------------------------------------------------------------------------
module aes_core (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic               i_step,
    input  logic [127:0]       i_block,
    input  aes_pkg::t_lane_ctl i_ctl,
    input  logic [127:0]       i_rkey,
    output logic [127:0]       o_state
);

    logic [127:0] r_state;
    logic [127:0] src;
    logic [127:0] n_state;
    logic [127:0] shifted;
    aes_pkg::t_lane_ctl lane_ctl;

    assign src = i_load ? i_block : r_state;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                shifted[127-32*c-8*r -: 8] = i_ctl.inv
                    ? src[127-32*((c+4-r)%4)-8*r -: 8]
                    : src[127-32*((c+r)%4)-8*r -: 8];
            end
        end
        lane_ctl = i_ctl;
        lane_ctl.first = i_load;
    end

    for (genvar c = 0; c < 4; c++) begin : g_lane
        aes_lane u_lane (
            .i_ctl (lane_ctl),
            .i_col (i_load ? src[127-32*c -: 32] : shifted[127-32*c -: 32]),
            .i_key (i_rkey[127-32*c -: 32]),
            .o_col (n_state[127-32*c -: 32])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_load || i_step) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

// ----- rtl/aes128_cbc_cipher_top.sv -----
// ----------------------------------------------------------------------------
// AES-128 CBC cipher top level
// Slave stream takes one 128-bit block per request, master stream returns
// one result block. Writes on the configuration port set key, IV and mode;
// a key write starts a round key expansion that holds tready low.
// A request passes the initial key add in the accept cycle, each round
// through four column lanes, and the output register. A new block is
// accepted only in idle, once the result of the last one is registered,
// so one block is finished before the next is taken.
// Reset clears the control state and registers (chain_enable comes up 1);
// blocks must not be sent before a key has been written and expanded.
// When the receiver stalls the result is held in the output register and
// one new block may be accepted and computed; it then waits in the round
// datapath, with tready low, until the output register is free.
// ----------------------------------------------------------------------------
module aes128_cbc_cipher_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [aes_pkg::CFG_BITS-1:0] i_cfg_index,
    input  logic [63:0]                  i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [127:0]                 s_axis_tdata,  // block_low, block_high
    input  logic                         s_axis_tuser,  // restart_chain
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [127:0]                 m_axis_tdata   // result_low, result_high
);

    logic [63:0]  r_key_high, r_key_low, r_iv_high, r_iv_low;
    logic         r_decrypt, r_chain_en;
    logic [127:0] r_chain, n_chain;
    logic [127:0] r_in;
    logic [aes_pkg::RND_BITS-1:0] r_rnd, n_rnd;
    aes_pkg::t_state r_state, n_state;
    logic         r_ovalid;
    logic [127:0] r_odata;
    logic         key_start, key_busy, load, finish;
    logic [127:0] blk_in, blk_pre, rkey, core_state, cipher_out;
    logic [aes_pkg::RND_BITS-1:0] key_sel;
    aes_pkg::t_lane_ctl ctl;

    assign blk_in = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign n_chain = s_axis_tuser ? {r_iv_high, r_iv_low} : r_chain;
    assign load = s_axis_tvalid && s_axis_tready;
    assign key_start = i_cfg_we && (i_cfg_index == aes_pkg::REG_KEY_HIGH
                                 || i_cfg_index == aes_pkg::REG_KEY_LOW);
    assign blk_pre = blk_in ^ ((!r_decrypt && r_chain_en) ? n_chain : 128'h0);

    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        finish  = 1'b0;
        s_axis_tready = 1'b0;
        case (r_state)
            aes_pkg::ST_IDLE: begin
                s_axis_tready = !key_busy;
                if (load) begin
                    n_state = aes_pkg::ST_RUN;
                    n_rnd   = aes_pkg::RND_BITS'(1);
                end
            end
            aes_pkg::ST_RUN: begin
                n_rnd = r_rnd + 1'b1;
                if (r_rnd == aes_pkg::RND_BITS'(aes_pkg::ROUND_COUNT)) begin
                    n_state = aes_pkg::ST_DONE;
                end
            end
            aes_pkg::ST_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    finish  = 1'b1;
                    n_state = aes_pkg::ST_IDLE;
                end
            end
            default: n_state = aes_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctl.inv   = r_decrypt;
        ctl.first = 1'b0;
        ctl.last  = (r_rnd == aes_pkg::RND_BITS'(aes_pkg::ROUND_COUNT));
        if (load) begin
            key_sel = r_decrypt ? aes_pkg::RND_BITS'(aes_pkg::ROUND_COUNT) : '0;
        end else begin
            key_sel = r_decrypt ? aes_pkg::RND_BITS'(aes_pkg::ROUND_COUNT) - r_rnd : r_rnd;
        end
    end

    aes_keyexp u_keyexp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (key_start),
        .i_key   ({i_cfg_index == aes_pkg::REG_KEY_HIGH ? i_cfg_data : r_key_high,
                   i_cfg_index == aes_pkg::REG_KEY_LOW  ? i_cfg_data : r_key_low}),
        .i_rnd   (key_sel),
        .o_rkey  (rkey),
        .o_busy  (key_busy)
    );

    aes_core u_core (
        .i_clk   (i_clk),
        .i_load  (load),
        .i_step  (r_state == aes_pkg::ST_RUN),
        .i_block (blk_pre),
        .i_ctl   (ctl),
        .i_rkey  (rkey),
        .o_state (core_state)
    );

    assign cipher_out = core_state ^ ((r_decrypt && r_chain_en) ? r_chain : 128'h0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= aes_pkg::ST_IDLE;
            r_rnd      <= '0;
            r_ovalid   <= 1'b0;
            r_key_high <= '0;
            r_key_low  <= '0;
            r_iv_high  <= '0;
            r_iv_low   <= '0;
            r_decrypt  <= 1'b0;
            r_chain_en <= 1'b1;
            r_chain    <= '0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            if (finish) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    aes_pkg::REG_KEY_HIGH:     r_key_high <= i_cfg_data;
                    aes_pkg::REG_KEY_LOW:      r_key_low  <= i_cfg_data;
                    aes_pkg::REG_IV_HIGH:      r_iv_high  <= i_cfg_data;
                    aes_pkg::REG_IV_LOW:       r_iv_low   <= i_cfg_data;
                    aes_pkg::REG_DECRYPT_MODE: r_decrypt  <= i_cfg_data[0];
                    aes_pkg::REG_CHAIN_ENABLE: r_chain_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (load) begin
                r_chain <= n_chain;
            end
            if (finish && r_chain_en) begin
                r_chain <= r_decrypt ? r_in : core_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in <= blk_in;
        end
        if (finish) begin
            r_odata <= cipher_out;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_odata[63:0], r_odata[127:64]};

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == aes_pkg::ST_IDLE)
        else $error("ready outside idle");
    a_no_load_keyexp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_busy |-> !load)
        else $error("block accepted during key expansion");
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> (!r_ovalid || m_axis_tready))
        else $error("result overwritten");
    a_run_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_state == aes_pkg::ST_RUN && r_rnd == aes_pkg::RND_BITS'(1))
        else $error("round counter not started");

endmodule

// ----- tb/tb_aes128_cbc_cipher_top.sv -----
// ----------------------------------------------------------------------------
// AES-128 CBC cipher testbench
// Drives blocks through the slave stream from a queue of pending requests,
// computes each expected result block with a local AES-128/CBC predictor,
// and checks the master stream in order. Phases change key, IV, direction
// and chaining while idle, under varied sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_aes128_cbc_cipher_top;

    localparam logic [aes_pkg::CFG_BITS-1:0] REG_UNUSED    = 3'd6;
    localparam logic [aes_pkg::CFG_BITS-1:0] REG_UNUSED_HI = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 30;

    typedef struct {
        logic [63:0] blk_hi;
        logic [63:0] blk_lo;
        logic        restart;
    } t_block_req;

    typedef struct {
        logic [63:0] res_hi;
        logic [63:0] res_lo;
    } t_block_res;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [aes_pkg::CFG_BITS-1:0] i_cfg_index;
    logic [63:0]                  i_cfg_data;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [127:0]                 s_axis_tdata;
    logic                         s_axis_tuser;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [127:0]                 m_axis_tdata;

    aes128_cbc_cipher_top i_dut (.*);

    // predictor state
    logic [31:0] rkeys [aes_pkg::KEY_WORDS];
    logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
    logic [63:0] chain_hi = '0;
    logic [63:0] chain_lo = '0;
    logic        decrypt, chain_on;

    t_block_req  pending_blocks[$];
    t_block_res  expected_blocks[$];
    int          send_idle_pct;
    int          stall_pct;
    int          errors = 0;
    int          blocks_sent = 0;
    int          blocks_offered = 0;
    int          blocks_checked = 0;
    int          cycles = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] gf_dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = gf_dbl(a);
        end
        return acc;
    endfunction

    task automatic expand_keys();
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        rkeys[0] = key_hi[63:32];
        rkeys[1] = key_hi[31:0];
        rkeys[2] = key_lo[63:32];
        rkeys[3] = key_lo[31:0];
        for (int i = 4; i < aes_pkg::KEY_WORDS; i++) begin
            t = rkeys[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {aes_pkg::SBOX[t[31:24]], aes_pkg::SBOX[t[23:16]],
                     aes_pkg::SBOX[t[15:8]], aes_pkg::SBOX[t[7:0]]};
                t ^= {rc, 24'h0};
                rc = gf_dbl(rc);
            end
            rkeys[i] = rkeys[i-4] ^ t;
        end
    endtask

    // byte n of the block sits at bits 127-8n; column c is word c
    function automatic logic [127:0] add_round_key(input logic [127:0] b, input int rnd);
        for (int c = 0; c < 4; c++) b[127-32*c -: 32] ^= rkeys[rnd*4+c];
        return b;
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] b, input logic inv);
        logic [127:0] o;
        int src;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
                o[127-8*(c*4+r) -: 8] = inv ? aes_pkg::RSBOX[b[127-8*(src*4+r) -: 8]]
                                            : aes_pkg::SBOX[b[127-8*(src*4+r) -: 8]];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] b, input logic inv);
        logic [7:0] m [4];
        logic [7:0] a [4];
        logic [7:0] acc;
        if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else     m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) a[j] = b[127-8*(c*4+j) -: 8];
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++) acc ^= gf_mul(m[(j + 4 - r) % 4], a[j]);
                b[127-8*(c*4+r) -: 8] = acc;
            end
        end
        return b;
    endfunction

    function automatic logic [127:0] aes_forward(input logic [127:0] b);
        b = add_round_key(b, 0);
        for (int rnd = 1; rnd < aes_pkg::ROUND_COUNT; rnd++)
            b = add_round_key(mix_columns(sub_shift(b, 1'b0), 1'b0), rnd);
        return add_round_key(sub_shift(b, 1'b0), aes_pkg::ROUND_COUNT);
    endfunction

    function automatic logic [127:0] aes_inverse(input logic [127:0] b);
        b = add_round_key(b, aes_pkg::ROUND_COUNT);
        for (int rnd = aes_pkg::ROUND_COUNT - 1; rnd > 0; rnd--)
            b = mix_columns(add_round_key(sub_shift(b, 1'b1), rnd), 1'b1);
        return add_round_key(sub_shift(b, 1'b1), 0);
    endfunction

    function automatic t_block_res cbc_block(input t_block_req rq);
        logic [127:0] b;
        t_block_res   rs;
        if (rq.restart) begin
            chain_hi = iv_hi;
            chain_lo = iv_lo;
        end
        b = {rq.blk_hi, rq.blk_lo};
        if (!decrypt) begin
            if (chain_on) b ^= {chain_hi, chain_lo};
            b = aes_forward(b);
            if (chain_on) {chain_hi, chain_lo} = b;
        end else begin
            b = aes_inverse(b);
            if (chain_on) begin
                b ^= {chain_hi, chain_lo};
                {chain_hi, chain_lo} = {rq.blk_hi, rq.blk_lo};
            end
        end
        {rs.res_hi, rs.res_lo} = b;
        return rs;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR t=%0t %s: got %016h expected %016h", $time, what, got, want);
        errors++;
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
            if (blocks_sent == blocks_offered) begin
                if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {pending_blocks[0].blk_lo, pending_blocks[0].blk_hi};
                    s_axis_tuser  <= pending_blocks[0].restart;
                    blocks_offered++;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // accept requests and predict
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_blocks.push_back(cbc_block(pending_blocks.pop_front()));
            blocks_sent++;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_block_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_blocks.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[63:0], 64'h0);
            end else begin
                want = expected_blocks.pop_front();
                if (m_axis_tdata[63:0] !== want.res_hi)
                    report_mismatch("result_high", m_axis_tdata[63:0], want.res_hi);
                if (m_axis_tdata[127:64] !== want.res_lo)
                    report_mismatch("result_low", m_axis_tdata[127:64], want.res_lo);
                blocks_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout: %0d results still expected", expected_blocks.size());
            $display("** aes128_cbc_cipher_top: FAILED **");
            $finish;
        end
    end

    task automatic cfg_write(input logic [aes_pkg::CFG_BITS-1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            aes_pkg::REG_KEY_HIGH:     begin key_hi = val; expand_keys(); end
            aes_pkg::REG_KEY_LOW:      begin key_lo = val; expand_keys(); end
            aes_pkg::REG_IV_HIGH:      iv_hi = val;
            aes_pkg::REG_IV_LOW:       iv_lo = val;
            aes_pkg::REG_DECRYPT_MODE: decrypt = val[0];
            aes_pkg::REG_CHAIN_ENABLE: chain_on = val[0];
            default: ;
        endcase
    endtask

    task automatic cfg_done();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (20) @(posedge i_clk);
    endtask

    task automatic push_block(input logic [63:0] hi, input logic [63:0] lo, input logic rs);
        t_block_req rq;
        rq.blk_hi = hi;
        rq.blk_lo = lo;
        rq.restart = rs;
        pending_blocks.push_back(rq);
    endtask

    task automatic drain();
        while (pending_blocks.size() != 0 || expected_blocks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [63:0] v;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
        decrypt = 1'b0;
        chain_on = 1'b1;
        foreach (rkeys[i]) rkeys[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // standard key, reset chaining (zero chain), encrypt
        cfg_write(aes_pkg::REG_KEY_HIGH, 64'h0001020304050607);
        cfg_write(aes_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        cfg_write(REG_UNUSED, '1);
        cfg_done();
        push_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        push_block('0, '0, 1'b0);
        push_block('1, '1, 1'b0);
        push_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        drain();

        // extreme key and IV, decrypt with chaining
        cfg_write(aes_pkg::REG_KEY_HIGH, '1);
        cfg_write(aes_pkg::REG_KEY_LOW, '1);
        cfg_write(aes_pkg::REG_IV_HIGH, '1);
        cfg_write(aes_pkg::REG_IV_LOW, '1);
        cfg_write(aes_pkg::REG_DECRYPT_MODE, 64'd1);
        cfg_done();
        push_block('0, '0, 1'b1);
        push_block('1, '1, 1'b0);
        push_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
        push_block('1, '0, 1'b1);
        drain();

        // zero key, single block both directions, restart without chaining
        cfg_write(aes_pkg::REG_KEY_HIGH, '0);
        cfg_write(aes_pkg::REG_KEY_LOW, '0);
        cfg_write(aes_pkg::REG_IV_HIGH, '0);
        cfg_write(aes_pkg::REG_IV_LOW, '0);
        cfg_write(aes_pkg::REG_CHAIN_ENABLE, 64'd0);
        cfg_done();
        push_block('0, '0, 1'b0);
        push_block('1, '1, 1'b1);
        drain();
        cfg_write(aes_pkg::REG_DECRYPT_MODE, 64'd0);
        cfg_done();
        push_block('0, '0, 1'b0);
        push_block('1, '1, 1'b1);
        push_block(64'h8000000000000001, 64'h0000000180000000, 1'b0);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 48; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 48; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            if (ph % 3 == 0) begin
                cfg_write(aes_pkg::REG_KEY_HIGH, rand64());
                cfg_write(aes_pkg::REG_KEY_LOW, rand64());
            end
            cfg_write(aes_pkg::REG_IV_HIGH, rand64());
            cfg_write(aes_pkg::REG_IV_LOW, rand64());
            cfg_write(aes_pkg::REG_DECRYPT_MODE, 64'($urandom_range(1)));
            cfg_write(aes_pkg::REG_CHAIN_ENABLE, (ph % 5 == 4) ? 64'd0 : 64'd1);
            if (ph == 7) cfg_write(REG_UNUSED_HI, rand64());
            cfg_done();
            for (int n = 0; n < 40; n++) begin
                v = rand64();
                push_block(v, rand64(), (n == 0) || ($urandom_range(99) < 12));
            end
            drain();
        end

        $display("covered %0d blocks (%0d checked): encrypt/decrypt, CBC and single-block,",
                 blocks_sent, blocks_checked);
        $display("restarts, extreme keys and IVs, sender gaps and receiver stalls");
        if (errors == 0) begin
            $display("** aes128_cbc_cipher_top: PASSED **");
        end else begin
            $display("** aes128_cbc_cipher_top: FAILED **");
        end
        $finish;
    end

endmodule
